// ===== rtl/cartesian_cell_to_simplex_indices_top_assert.svh =====
// Assertion macros shared by the cell splitter RTL.
// Used by ccsi_fifo and ccsi_back; no other dependencies.
`ifndef CARTESIAN_CELL_TO_SIMPLEX_INDICES_TOP_ASSERT_SVH
`define CARTESIAN_CELL_TO_SIMPLEX_INDICES_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CCSI_ASSERT_IMPLIES(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CCSI_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccsi_pkg.sv =====
// Shared types, constants and corner tables of the cell splitter.
// No dependencies; every RTL module refers to it by scoped names.
package ccsi_pkg;

    localparam int MAX_POINTS_PER_AXIS = 1024;
    localparam int QUEUE_DEPTH         = 8;

    localparam int COORD_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int VERTEX_W    = 31;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int PLANE_W     = 2 * COUNT_W;
    localparam int PROD_J_W    = COORD_W + COUNT_W;
    localparam int STEP_W      = 3;
    localparam int NUM_TETRA   = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_I = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_J = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_K = 2'd2;

    localparam logic [COUNT_W-1:0] POINTS_RESET = 11'd2;

    // Element kind codes on the output
    localparam logic [KIND_W-1:0] KIND_BAR      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TETRA    = 2'd2;

    typedef enum logic [1:0] {
        CLS_ERROR    = 2'd0,
        CLS_BAR      = 2'd1,
        CLS_TRIANGLE = 2'd2,
        CLS_TETRA    = 2'd3
    } cell_class_t;

    typedef struct packed {
        logic [COORD_W-1:0] cell_i;
        logic [COORD_W-1:0] cell_j;
        logic [COORD_W-1:0] cell_k;
    } cell_t;

    typedef struct packed {
        logic [KIND_W-1:0]   element_kind;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        logic [VERTEX_W-1:0] vertex_d;
        logic                last_of_cell;
        logic                cell_error;
    } element_t;

    // Corner code: bit 0 steps i, bit 1 steps j, bit 2 steps k
    typedef logic [2:0] corner_t;

    localparam corner_t CORNER_A = 3'b000;
    localparam corner_t CORNER_B = 3'b001;
    localparam corner_t CORNER_C = 3'b011;
    localparam corner_t CORNER_D = 3'b010;
    localparam corner_t CORNER_E = 3'b100;
    localparam corner_t CORNER_F = 3'b101;
    localparam corner_t CORNER_G = 3'b111;
    localparam corner_t CORNER_H = 3'b110;

    typedef struct packed {
        corner_t a;
        corner_t b;
        corner_t c;
        corner_t d;
    } corner_set_t;

    // Classified cell handed from the front to the back
    typedef struct packed {
        cell_class_t          cls;
        logic                 parity;
        corner_t              dir_u;
        corner_t              dir_v;
        logic [VERTEX_W-1:0]  base;
        logic [COUNT_W-1:0]   stride_j;
        logic [PLANE_W-1:0]   stride_k;
    } job_t;

    localparam corner_set_t TET_EVEN [NUM_TETRA] = '{
        '{CORNER_A, CORNER_B, CORNER_D, CORNER_E},
        '{CORNER_B, CORNER_C, CORNER_D, CORNER_G},
        '{CORNER_D, CORNER_E, CORNER_G, CORNER_H},
        '{CORNER_B, CORNER_E, CORNER_F, CORNER_G},
        '{CORNER_B, CORNER_D, CORNER_E, CORNER_G}
    };

    localparam corner_set_t TET_ODD [NUM_TETRA] = '{
        '{CORNER_A, CORNER_C, CORNER_D, CORNER_H},
        '{CORNER_A, CORNER_F, CORNER_B, CORNER_C},
        '{CORNER_H, CORNER_G, CORNER_F, CORNER_C},
        '{CORNER_F, CORNER_H, CORNER_A, CORNER_E},
        '{CORNER_F, CORNER_A, CORNER_H, CORNER_C}
    };

    // Index of the final element of a cell of the given class
    function automatic logic [STEP_W-1:0] class_last_step(cell_class_t cls);
        logic [STEP_W-1:0] last;
        case (cls)
            CLS_TRIANGLE: last = STEP_W'(1);
            CLS_TETRA:    last = STEP_W'(NUM_TETRA - 1);
            default:      last = '0;
        endcase
        return last;
    endfunction

    // Corners used by one element of a cell
    function automatic corner_set_t select_corners(cell_class_t cls, logic parity,
                                                   logic [STEP_W-1:0] step,
                                                   corner_t dir_u, corner_t dir_v);
        corner_set_t sel;
        sel = '0;
        case (cls)
            CLS_TETRA:
            begin
                sel = parity ? TET_ODD[step] : TET_EVEN[step];
            end
            CLS_TRIANGLE:
            begin
                sel.a = CORNER_A;
                if (step[0] == 1'b0)
                begin
                    sel.b = dir_u;
                    sel.c = dir_u | dir_v;
                end
                else
                begin
                    sel.b = dir_u | dir_v;
                    sel.c = dir_v;
                end
            end
            CLS_BAR:
            begin
                sel.a = CORNER_A;
                sel.b = dir_u;
            end
            default:
            begin
                sel = '0;
            end
        endcase
        return sel;
    endfunction

endpackage

// ===== rtl/ccsi_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Payload types come from ccsi_pkg at the instance.
interface ccsi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ccsi_fifo.sv =====
// Short flop-based queue of classified cells between front and back.
// Depends on ccsi_pkg and the assertion header.
`include "cartesian_cell_to_simplex_indices_top_assert.svh"

module ccsi_fifo #(
    parameter int DEPTH = ccsi_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ccsi_pkg::job_t             push_data,
    input  logic                       pop,
    output ccsi_pkg::job_t             head,
    output logic                       head_valid,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccsi_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    `CCSI_ASSERT_IMPLIES(a_fifo_no_overflow, clk, rst_n, push, count_reg != CNT_W'(DEPTH),
        "ccsi_fifo: push into a full queue")
    `CCSI_ASSERT_IMPLIES(a_fifo_no_underflow, clk, rst_n, pop, count_reg != '0,
        "ccsi_fifo: pop from an empty queue")

endmodule

// ===== rtl/ccsi_front.sv =====
// Front part: configuration registers, cell acceptance, range checks,
// classification and base index arithmetic over three stages. Depends on ccsi_pkg.
module ccsi_front #(
    parameter int MAX_POINTS_PER_AXIS = ccsi_pkg::MAX_POINTS_PER_AXIS,
    parameter int QUEUE_DEPTH         = ccsi_pkg::QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ccsi_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ccsi_pkg::COUNT_W-1:0]          cfg_data,
    ccsi_stream_if.sink                           cells,
    output logic                                  push,
    output ccsi_pkg::job_t                        push_data,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_count
);

    localparam int COORD_W  = ccsi_pkg::COORD_W;
    localparam int COUNT_W  = ccsi_pkg::COUNT_W;
    localparam int VERTEX_W = ccsi_pkg::VERTEX_W;
    localparam int PLANE_W  = ccsi_pkg::PLANE_W;
    localparam int PROD_J_W = ccsi_pkg::PROD_J_W;
    localparam int PROD_K_W = COORD_W + PLANE_W;

    logic [COUNT_W-1:0] points_i_reg, points_j_reg, points_k_reg;

    // Stage 1: accepted cell
    logic               s1_valid_reg;
    ccsi_pkg::cell_t    s1_cell_reg;

    // Stage 2: classification and first products
    logic                   s2_valid_reg;
    ccsi_pkg::cell_class_t  s2_cls_reg, s1_cls;
    logic                   s2_parity_reg, s1_parity;
    ccsi_pkg::corner_t      s2_dir_u_reg, s2_dir_v_reg, s1_dir_u, s1_dir_v;
    logic [COORD_W-1:0]     s2_cell_i_reg, s2_cell_k_reg;
    logic [PROD_J_W-1:0]    s2_prod_j_reg;
    logic [COUNT_W-1:0]     s2_stride_j_reg;
    logic [PLANE_W-1:0]     s2_stride_k_reg;

    // Stage 3: partial sums of the base index
    logic                   s3_valid_reg;
    ccsi_pkg::cell_class_t  s3_cls_reg;
    logic                   s3_parity_reg;
    ccsi_pkg::corner_t      s3_dir_u_reg, s3_dir_v_reg;
    logic [COUNT_W-1:0]     s3_stride_j_reg;
    logic [PLANE_W-1:0]     s3_stride_k_reg;
    logic [VERTEX_W-1:0]    s3_partial_reg, s3_prod_k_reg;

    logic [COUNT_W-1:0] pts [3];
    logic [COORD_W-1:0] crd [3];
    logic [2:0]         active;
    logic [2:0]         axis_bad;
    logic               any_bad;
    logic [PROD_K_W-1:0] s2_prod_k;
    int                 occupancy;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_i_reg <= ccsi_pkg::POINTS_RESET;
            points_j_reg <= ccsi_pkg::POINTS_RESET;
            points_k_reg <= ccsi_pkg::POINTS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ccsi_pkg::CFG_POINTS_I: points_i_reg <= cfg_data;
                ccsi_pkg::CFG_POINTS_J: points_j_reg <= cfg_data;
                ccsi_pkg::CFG_POINTS_K: points_k_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Take a cell only when the queue has room for everything in flight
    assign occupancy = int'(queue_count) + int'(s1_valid_reg) + int'(s2_valid_reg)
                     + int'(s3_valid_reg);
    assign cells.ready = (occupancy < QUEUE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cells.valid && cells.ready;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cell_reg <= cells.payload;
    end

    // Check each axis against its point count
    assign pts[0] = points_i_reg;
    assign pts[1] = points_j_reg;
    assign pts[2] = points_k_reg;
    assign crd[0] = s1_cell_reg.cell_i;
    assign crd[1] = s1_cell_reg.cell_j;
    assign crd[2] = s1_cell_reg.cell_k;

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            active[ax]   = (pts[ax] != COUNT_W'(1));
            axis_bad[ax] = (pts[ax] == '0)
                        || (32'(pts[ax]) > 32'(MAX_POINTS_PER_AXIS))
                        || (active[ax] ? (({1'b0, crd[ax]} + COUNT_W'(1)) >= pts[ax])
                                       : (crd[ax] != '0));
        end
    end

    assign any_bad = (|axis_bad) || (active == 3'b000);

    // Classify by the number of active axes and pick the plane directions
    always_comb
    begin
        s1_dir_u = '0;
        s1_dir_v = '0;
        case (active)
            3'b011:
            begin
                s1_dir_u = ccsi_pkg::CORNER_B;
                s1_dir_v = ccsi_pkg::CORNER_D;
            end
            3'b110:
            begin
                s1_dir_u = ccsi_pkg::CORNER_D;
                s1_dir_v = ccsi_pkg::CORNER_E;
            end
            3'b101:
            begin
                // i-k plane walks k first
                s1_dir_u = ccsi_pkg::CORNER_E;
                s1_dir_v = ccsi_pkg::CORNER_B;
            end
            default:
            begin
                s1_dir_u = ccsi_pkg::corner_t'(active);
                s1_dir_v = '0;
            end
        endcase

        if (any_bad)
        begin
            s1_cls = ccsi_pkg::CLS_ERROR;
        end
        else
        begin
            case ($countones(active))
                1:       s1_cls = ccsi_pkg::CLS_BAR;
                2:       s1_cls = ccsi_pkg::CLS_TRIANGLE;
                3:       s1_cls = ccsi_pkg::CLS_TETRA;
                default: s1_cls = ccsi_pkg::CLS_ERROR;
            endcase
        end
    end

    assign s1_parity = s1_cell_reg.cell_i[0] ^ s1_cell_reg.cell_j[0] ^ s1_cell_reg.cell_k[0];

    // Stage 2 registers: j offset and plane stride products
    always_ff @(posedge clk)
    begin
        s2_cls_reg      <= s1_cls;
        s2_parity_reg   <= s1_parity;
        s2_dir_u_reg    <= s1_dir_u;
        s2_dir_v_reg    <= s1_dir_v;
        s2_cell_i_reg   <= s1_cell_reg.cell_i;
        s2_cell_k_reg   <= s1_cell_reg.cell_k;
        s2_prod_j_reg   <= PROD_J_W'(s1_cell_reg.cell_j) * PROD_J_W'(points_i_reg);
        s2_stride_j_reg <= points_i_reg;
        s2_stride_k_reg <= PLANE_W'(points_i_reg) * PLANE_W'(points_j_reg);
    end

    // Stage 3 registers: k offset product and the rest of the sum
    assign s2_prod_k = PROD_K_W'(s2_cell_k_reg) * PROD_K_W'(s2_stride_k_reg);

    always_ff @(posedge clk)
    begin
        s3_cls_reg      <= s2_cls_reg;
        s3_parity_reg   <= s2_parity_reg;
        s3_dir_u_reg    <= s2_dir_u_reg;
        s3_dir_v_reg    <= s2_dir_v_reg;
        s3_stride_j_reg <= s2_stride_j_reg;
        s3_stride_k_reg <= s2_stride_k_reg;
        s3_prod_k_reg   <= s2_prod_k[VERTEX_W-1:0];
        s3_partial_reg  <= VERTEX_W'(1) + VERTEX_W'(s2_cell_i_reg) + VERTEX_W'(s2_prod_j_reg);
    end

    // Finish the base index and hand the job to the queue
    assign push               = s3_valid_reg;
    assign push_data.cls      = s3_cls_reg;
    assign push_data.parity   = s3_parity_reg;
    assign push_data.dir_u    = s3_dir_u_reg;
    assign push_data.dir_v    = s3_dir_v_reg;
    assign push_data.base     = s3_partial_reg + s3_prod_k_reg;
    assign push_data.stride_j = s3_stride_j_reg;
    assign push_data.stride_k = s3_stride_k_reg;

endmodule

// ===== rtl/ccsi_back.sv =====
// Back part: walks the elements of the queued cell, one a cycle unless stalled,
// into the output register. Depends on ccsi_pkg and the assertion header.
`include "cartesian_cell_to_simplex_indices_top_assert.svh"

module ccsi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ccsi_pkg::job_t  head,
    input  logic            head_valid,
    output logic            pop,
    ccsi_stream_if.source   elements
);

    localparam int VERTEX_W = ccsi_pkg::VERTEX_W;
    localparam int STEP_W   = ccsi_pkg::STEP_W;

    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    ccsi_pkg::element_t     out_data_reg, result;
    ccsi_pkg::corner_set_t  sel;
    logic                   load;
    logic                   is_last;

    // Vertex index of one corner of the cell
    function automatic logic [VERTEX_W-1:0] corner_index(
        logic [VERTEX_W-1:0]          base,
        ccsi_pkg::corner_t            code,
        logic [ccsi_pkg::COUNT_W-1:0] stride_j,
        logic [ccsi_pkg::PLANE_W-1:0] stride_k
    );
        logic [VERTEX_W-1:0] off_j;
        logic [VERTEX_W-1:0] off_k;
        off_j = code[1] ? VERTEX_W'(stride_j) : '0;
        off_k = code[2] ? VERTEX_W'(stride_k) : '0;
        return base + VERTEX_W'(code[0]) + off_j + off_k;
    endfunction

    assign load    = head_valid && (!out_valid_reg || elements.ready);
    assign is_last = (step_reg == ccsi_pkg::class_last_step(head.cls));
    assign pop     = load && is_last;

    assign sel = ccsi_pkg::select_corners(head.cls, head.parity, step_reg,
                                          head.dir_u, head.dir_v);

    // Build the element for the current step
    always_comb
    begin
        result              = '0;
        result.last_of_cell = is_last;
        case (head.cls)
            ccsi_pkg::CLS_TETRA:
            begin
                result.element_kind = ccsi_pkg::KIND_TETRA;
                result.vertex_a = corner_index(head.base, sel.a, head.stride_j, head.stride_k);
                result.vertex_b = corner_index(head.base, sel.b, head.stride_j, head.stride_k);
                result.vertex_c = corner_index(head.base, sel.c, head.stride_j, head.stride_k);
                result.vertex_d = corner_index(head.base, sel.d, head.stride_j, head.stride_k);
            end
            ccsi_pkg::CLS_TRIANGLE:
            begin
                result.element_kind = ccsi_pkg::KIND_TRIANGLE;
                result.vertex_a = corner_index(head.base, sel.a, head.stride_j, head.stride_k);
                result.vertex_b = corner_index(head.base, sel.b, head.stride_j, head.stride_k);
                result.vertex_c = corner_index(head.base, sel.c, head.stride_j, head.stride_k);
            end
            ccsi_pkg::CLS_BAR:
            begin
                result.element_kind = ccsi_pkg::KIND_BAR;
                result.vertex_a = corner_index(head.base, sel.a, head.stride_j, head.stride_k);
                result.vertex_b = corner_index(head.base, sel.b, head.stride_j, head.stride_k);
            end
            default:
            begin
                result.element_kind = ccsi_pkg::KIND_BAR;
                result.cell_error   = 1'b1;
                result.last_of_cell = 1'b1;
            end
        endcase
    end

    // Advance the step counter; clear it when the cell is done
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = is_last ? '0 : step_reg + STEP_W'(1);
            out_valid_next = 1'b1;
        end
        else if (elements.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the element until the transaction completes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign elements.valid   = out_valid_reg;
    assign elements.payload = out_data_reg;

    `CCSI_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop,
        out_valid_reg && out_data_reg.last_of_cell,
        "ccsi_back: cell retired without a last element")
    `CCSI_ASSERT_IMPLIES(a_error_is_empty, clk, rst_n, out_valid_reg && out_data_reg.cell_error,
        out_data_reg.vertex_a == '0 && out_data_reg.vertex_b == '0 && out_data_reg.last_of_cell,
        "ccsi_back: error element carries vertices")
    `CCSI_ASSERT_IMPLIES(a_step_in_range, clk, rst_n, head_valid,
        step_reg <= ccsi_pkg::class_last_step(head.cls),
        "ccsi_back: step beyond the element count of the cell")

endmodule

// ===== rtl/cartesian_cell_to_simplex_indices_top.sv =====
// Top level of the structured cell to simplex splitter.
// Instantiates ccsi_front, ccsi_fifo and ccsi_back; uses ccsi_pkg and ccsi_stream_if.
//
//  Channel    Dir  Payload                                           Handshake
//  ---------  ---  ------------------------------------------------  ------------
//  cells      in   cell_i, cell_j, cell_k                            valid/ready
//  elements   out  element_kind, vertex_a..d, last_of_cell, error    valid/ready
//  cfg        in   cfg_index (0 i, 1 j, 2 k), cfg_data               cfg_we only
//
// A cell yields 1 (bar or error), 2 (triangles) or 5 (tetrahedra) elements, one
// per cycle from the back's step counter unless the output stalls; the front takes
// one cell per cycle while cells.ready is high.
// An accepted cell passes the front stages and the queue into the output register.
// Reset sets all point counts to 2 and empties the pipeline and the 8-entry queue.
// An output stall fills the queue; cells.ready drops once the queue plus cells in
// the front's three stages reach the queue depth.
module cartesian_cell_to_simplex_indices_top #(
    parameter int MAX_POINTS_PER_AXIS = ccsi_pkg::MAX_POINTS_PER_AXIS,
    parameter int QUEUE_DEPTH         = ccsi_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ccsi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ccsi_pkg::COUNT_W-1:0]     cfg_data,
    ccsi_stream_if.sink                      cells,
    ccsi_stream_if.source                    elements
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               push;
    ccsi_pkg::job_t     push_data;
    logic               pop;
    ccsi_pkg::job_t     head;
    logic               head_valid;
    logic [CNT_W-1:0]   queue_count;

    // Accept, check and classify cells
    ccsi_front #(
        .MAX_POINTS_PER_AXIS (MAX_POINTS_PER_AXIS),
        .QUEUE_DEPTH         (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cells       (cells),
        .push        (push),
        .push_data   (push_data),
        .queue_count (queue_count)
    );

    // Decouple front and back
    ccsi_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .count      (queue_count)
    );

    // Emit the elements of each cell
    ccsi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .elements   (elements)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for cartesian_cell_to_simplex_indices_top.
// Needs ccsi_pkg, ccsi_stream_if and the RTL. An in-bench splitter predicts every
// element; directed cells come first, then random grids under several idling mixes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W             = ccsi_pkg::COORD_W;
    localparam int COUNT_W             = ccsi_pkg::COUNT_W;
    localparam int VERTEX_W            = ccsi_pkg::VERTEX_W;
    localparam int KIND_W              = ccsi_pkg::KIND_W;
    localparam int CFG_INDEX_W         = ccsi_pkg::CFG_INDEX_W;
    localparam int MAX_POINTS_PER_AXIS = ccsi_pkg::MAX_POINTS_PER_AXIS;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 3;
    // Margin after the drain so the pipeline settles
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 40;
    // Hard limit on the run time, in ns
    localparam int TIMEOUT_NS = 2000000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]     cfg_data;
    logic                   hold_active;

    ccsi_stream_if #(.payload_t(ccsi_pkg::cell_t))    cell_chan ();
    ccsi_stream_if #(.payload_t(ccsi_pkg::element_t)) element_chan ();

    // Point counts as the block should hold them
    logic [COUNT_W-1:0]  grid_points [3];
    ccsi_pkg::element_t  pending_elements [$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    cartesian_cell_to_simplex_indices_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cell_chan),
        .elements  (element_chan)
    );

    // Free-running clock
    always #(CLK_HALF) clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("cartesian_cell_to_simplex_indices_top verification failed");
        $finish;
    end

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(input string what, input ccsi_pkg::element_t got,
                                   input ccsi_pkg::element_t want);
        string got_s;
        string want_s;
        got_s  = $sformatf("k=%0d a=%0d b=%0d c=%0d d=%0d l=%0b e=%0b",
                           got.element_kind, got.vertex_a, got.vertex_b, got.vertex_c,
                           got.vertex_d, got.last_of_cell, got.cell_error);
        want_s = $sformatf("k=%0d a=%0d b=%0d c=%0d d=%0d l=%0b e=%0b",
                           want.element_kind, want.vertex_a, want.vertex_b, want.vertex_c,
                           want.vertex_d, want.last_of_cell, want.cell_error);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH %s @%0t: got %s | want %s", what, $realtime, got_s, want_s);
        mismatch_count++;
    endtask

    function automatic void push_element(input logic [KIND_W-1:0] kind,
                                         input longint unsigned a, input longint unsigned b,
                                         input longint unsigned c, input longint unsigned d,
                                         input logic last, input logic err);
        ccsi_pkg::element_t e;
        e.element_kind = kind;
        e.vertex_a     = VERTEX_W'(a);
        e.vertex_b     = VERTEX_W'(b);
        e.vertex_c     = VERTEX_W'(c);
        e.vertex_d     = VERTEX_W'(d);
        e.last_of_cell = last;
        e.cell_error   = err;
        pending_elements.push_back(e);
    endfunction

    // Split one cell into the elements the block must emit, in order
    function automatic void split_cell(input ccsi_pkg::cell_t cell_in);
        longint unsigned n [3];
        longint unsigned crd [3];
        longint unsigned stride [3];
        longint unsigned lim, va, vb, vc, vd, ve, vf, vg, vh, u, v, swap;
        int act [3];
        int na;
        int ones;
        bit bad;
        n[0]   = 64'(grid_points[0]);
        n[1]   = 64'(grid_points[1]);
        n[2]   = 64'(grid_points[2]);
        crd[0] = 64'(cell_in.cell_i);
        crd[1] = 64'(cell_in.cell_j);
        crd[2] = 64'(cell_in.cell_k);
        na     = 0;
        ones   = 0;
        bad    = 1'b0;
        // Reject bad counts and cells outside the grid
        for (int ax = 0; ax < 3; ax++)
        begin
            if (n[ax] == 0 || n[ax] > MAX_POINTS_PER_AXIS)
                bad = 1'b1;
            if (n[ax] == 1)
                ones++;
            else
            begin
                act[na] = ax;
                na++;
            end
            lim = (n[ax] > 1) ? n[ax] - 1 : 1;
            if (crd[ax] >= lim)
                bad = 1'b1;
        end
        if (ones == 3)
            bad = 1'b1;
        if (bad)
        begin
            push_element(ccsi_pkg::KIND_BAR, 0, 0, 0, 0, 1'b1, 1'b1);
            return;
        end

        stride[0] = 1;
        stride[1] = n[0];
        stride[2] = n[0] * n[1];
        va = 1 + crd[0] * stride[0] + crd[1] * stride[1] + crd[2] * stride[2];

        if (na == 1)
        begin
            push_element(ccsi_pkg::KIND_BAR, va, va + stride[act[0]], 0, 0, 1'b1, 1'b0);
            return;
        end
        if (na == 2)
        begin
            u = stride[act[0]];
            v = stride[act[1]];
            // The i-k plane walks k first
            if (act[0] == 0 && act[1] == 2)
            begin
                swap = u;
                u    = v;
                v    = swap;
            end
            push_element(ccsi_pkg::KIND_TRIANGLE, va, va + u, va + u + v, 0, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TRIANGLE, va, va + u + v, va + v, 0, 1'b1, 1'b0);
            return;
        end

        vb = va + 1;
        vc = vb + stride[1];
        vd = vc - 1;
        ve = va + stride[2];
        vf = vb + stride[2];
        vg = vc + stride[2];
        vh = vd + stride[2];
        // Parity of i+j+k picks the pattern so shared faces agree
        if (((crd[0] + crd[1] + crd[2]) & 1) == 0)
        begin
            push_element(ccsi_pkg::KIND_TETRA, va, vb, vd, ve, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vb, vc, vd, vg, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vd, ve, vg, vh, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vb, ve, vf, vg, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vb, vd, ve, vg, 1'b1, 1'b0);
        end
        else
        begin
            push_element(ccsi_pkg::KIND_TETRA, va, vc, vd, vh, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, va, vf, vb, vc, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vh, vg, vf, vc, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vf, vh, va, ve, 1'b0, 1'b0);
            push_element(ccsi_pkg::KIND_TETRA, vf, va, vh, vc, 1'b1, 1'b0);
        end
    endfunction

    // Drive ready, dropping it at random or for the whole hold-off
    always @(posedge clk)
        element_chan.ready <= rst_n && !hold_active && ($urandom_range(99) >= recv_stall_pct);

    // Check each element transaction mid-cycle, ahead of the edge that takes it
    always @(negedge clk)
    begin
        if (rst_n && element_chan.valid && element_chan.ready)
            check_element(element_chan.payload);
    end

    task automatic check_element(input ccsi_pkg::element_t got);
        ccsi_pkg::element_t want;
        if (pending_elements.size() == 0)
        begin
            report_mismatch("element with no cell pending", got, '0);
            return;
        end
        want = pending_elements.pop_front();
        if (got.element_kind !== want.element_kind)
            report_mismatch("element_kind", got, want);
        if (got.vertex_a !== want.vertex_a)
            report_mismatch("vertex_a", got, want);
        if (got.vertex_b !== want.vertex_b)
            report_mismatch("vertex_b", got, want);
        if (got.vertex_c !== want.vertex_c)
            report_mismatch("vertex_c", got, want);
        if (got.vertex_d !== want.vertex_d)
            report_mismatch("vertex_d", got, want);
        if (got.last_of_cell !== want.last_of_cell)
            report_mismatch("last_of_cell", got, want);
        if (got.cell_error !== want.cell_error)
            report_mismatch("cell_error", got, want);
    endtask

    function automatic ccsi_pkg::cell_t make_cell(input int ci, input int cj, input int ck);
        ccsi_pkg::cell_t c;
        c.cell_i = COORD_W'(ci);
        c.cell_j = COORD_W'(cj);
        c.cell_k = COORD_W'(ck);
        return c;
    endfunction

    // Offer one cell after a random gap; predict once ready is seen, ahead of the accepting edge
    task automatic send_cell(input ccsi_pkg::cell_t cell_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_chan.valid <= 1'b0;
            @(posedge clk);
        end
        cell_chan.valid   <= 1'b1;
        cell_chan.payload <= cell_in;
        forever
        begin
            @(negedge clk);
            if (cell_chan.ready)
                break;
            @(posedge clk);
        end
        split_cell(cell_in);
        @(posedge clk);
    endtask

    // Raise cfg_we with the index and data and mirror the write; the caller lowers cfg_we
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ccsi_pkg::CFG_POINTS_I: grid_points[0] = val;
            ccsi_pkg::CFG_POINTS_J: grid_points[1] = val;
            ccsi_pkg::CFG_POINTS_K: grid_points[2] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [COUNT_W-1:0] ni, input logic [COUNT_W-1:0] nj,
                            input logic [COUNT_W-1:0] nk);
        write_reg(ccsi_pkg::CFG_POINTS_I, ni);
        write_reg(ccsi_pkg::CFG_POINTS_J, nj);
        write_reg(ccsi_pkg::CFG_POINTS_K, nk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every pending element up to the drain limit, then let the pipe settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        cell_chan.valid <= 1'b0;
        while (pending_elements.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly cells inside the grid, some on its edge, some anywhere
    function automatic ccsi_pkg::cell_t random_cell();
        int crd [3];
        int n;
        int pick;
        int ax;
        for (int a = 0; a < 3; a++)
        begin
            n = int'(grid_points[a]);
            if (n >= 2 && n <= MAX_POINTS_PER_AXIS)
                crd[a] = $urandom_range(n - 2, 0);
            else
                crd[a] = 0;
        end
        pick = $urandom_range(99);
        if (pick >= 90)
        begin
            crd[0] = $urandom_range(1023, 0);
            crd[1] = $urandom_range(1023, 0);
            crd[2] = $urandom_range(1023, 0);
        end
        else if (pick >= 80)
        begin
            ax = $urandom_range(2, 0);
            n  = int'(grid_points[ax]);
            crd[ax] = (n > 1) ? ((n - 1 > 1023) ? 1023 : n - 1) : 1;
        end
        return make_cell(crd[0], crd[1], crd[2]);
    endfunction

    // Random set of active axes; mostly small counts, sometimes up to the maximum
    task automatic pick_random_grid();
        int mask;
        int r;
        logic [COUNT_W-1:0] cnt [3];
        mask = $urandom_range(7, 1);
        if ($urandom_range(19) == 0)
            mask = 0;
        for (int ax = 0; ax < 3; ax++)
        begin
            r = $urandom_range(9);
            if (!mask[ax])
                cnt[ax] = 11'd1;
            else if (r < 7)
                cnt[ax] = COUNT_W'($urandom_range(9, 2));
            else if (r < 9)
                cnt[ax] = COUNT_W'($urandom_range(MAX_POINTS_PER_AXIS, 2));
            else
                cnt[ax] = $urandom_range(1) ? COUNT_W'(MAX_POINTS_PER_AXIS) : 11'd2;
        end
        set_grid(cnt[0], cnt[1], cnt[2]);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Each pattern, plane and axis, plus cells just outside the grid
    task automatic test_directed();
        // Reset counts: one even 3D cell and two rejects
        send_cell(make_cell(0, 0, 0));
        send_cell(make_cell(1, 0, 0));
        send_cell(make_cell(0, 0, 1023));
        wait_drained();
        // Both tetra patterns
        set_grid(11'd3, 11'd3, 11'd3);
        send_cell(make_cell(1, 0, 0));
        send_cell(make_cell(1, 1, 1));
        send_cell(make_cell(0, 1, 1));
        send_cell(make_cell(2, 0, 0));
        wait_drained();
        // i-j plane
        set_grid(11'd4, 11'd3, 11'd1);
        send_cell(make_cell(2, 1, 0));
        send_cell(make_cell(0, 0, 1));
        wait_drained();
        // i-k plane, whose second triangle uses corner (i+1,k)
        set_grid(11'd3, 11'd1, 11'd4);
        send_cell(make_cell(1, 0, 2));
        wait_drained();
        // j-k plane
        set_grid(11'd1, 11'd3, 11'd5);
        send_cell(make_cell(0, 1, 3));
        wait_drained();
        // Bars along each axis
        set_grid(11'd5, 11'd1, 11'd1);
        send_cell(make_cell(3, 0, 0));
        send_cell(make_cell(0, 1, 0));
        wait_drained();
        set_grid(11'd1, 11'd6, 11'd1);
        send_cell(make_cell(0, 4, 0));
        wait_drained();
        set_grid(11'd1, 11'd1, 11'd7);
        send_cell(make_cell(0, 0, 5));
        wait_drained();
        // Single point grid
        set_grid(11'd1, 11'd1, 11'd1);
        send_cell(make_cell(0, 0, 0));
        wait_drained();
        // Largest grid: top vertex index reaches bit 30
        set_grid(COUNT_W'(MAX_POINTS_PER_AXIS), COUNT_W'(MAX_POINTS_PER_AXIS),
                 COUNT_W'(MAX_POINTS_PER_AXIS));
        send_cell(make_cell(1022, 1022, 1022));
        send_cell(make_cell(1021, 1022, 1022));
        send_cell(make_cell(1023, 0, 0));
        send_cell(make_cell(0, 0, 0));
        wait_drained();
    endtask

    // Zero and oversized counts, and a write to an index past the list
    task automatic test_config_limits();
        set_grid(11'd0, 11'd2, 11'd2);
        send_cell(make_cell(0, 0, 0));
        wait_drained();
        set_grid(11'd2, COUNT_W'(MAX_POINTS_PER_AXIS), COUNT_W'(MAX_POINTS_PER_AXIS + 1));
        send_cell(make_cell(0, 0, 0));
        wait_drained();
        set_grid(11'd2047, 11'd2047, 11'd2047);
        send_cell(make_cell(5, 5, 5));
        wait_drained();
        set_grid(11'd2, 11'd2, 11'd2);
        write_reg(CFG_UNUSED_INDEX, 11'd2047);
        cfg_we <= 1'b0;
        send_cell(make_cell(0, 0, 0));
        wait_drained();
    endtask

    // Batches of random cells over a sequence of random grids
    task automatic test_random_grids(input int num_cells);
        int sent;
        int batch;
        sent = 0;
        while (sent < num_cells)
        begin
            pick_random_grid();
            batch = $urandom_range(30, 10);
            repeat (batch) send_cell(random_cell());
            sent += batch;
            wait_drained();
        end
    endtask

    // Receiver holds off while cells keep coming, so the input stalls
    task automatic test_backpressure();
        set_idling(0, 0);
        set_grid(11'd6, 11'd5, 11'd4);
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        repeat (60) send_cell(random_cell());
        wait_drained();
    endtask

    initial
    begin : main
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = ccsi_pkg::CFG_POINTS_I;
        cfg_data          = '0;
        hold_active       = 1'b0;
        cell_chan.valid   = 1'b0;
        cell_chan.payload = '0;
        element_chan.ready = 1'b0;
        mismatch_count    = 0;
        grid_points[0]    = ccsi_pkg::POINTS_RESET;
        grid_points[1]    = ccsi_pkg::POINTS_RESET;
        grid_points[2]    = ccsi_pkg::POINTS_RESET;
        set_idling(0, 0);

        // Release reset between edges
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_directed();
        test_config_limits();
        set_idling(0, 0);
        test_random_grids(90);
        set_idling(83, 0);
        test_random_grids(90);
        set_idling(0, 83);
        test_random_grids(90);
        set_idling(13, 13);
        test_random_grids(90);
        test_backpressure();

        // Anything still pending after the drain limit is lost
        wait_drained();
        while (pending_elements.size() != 0)
            report_mismatch("element never emitted", '0, pending_elements.pop_front());

        if (mismatch_count == 0)
            $display("cartesian_cell_to_simplex_indices_top verification clean");
        else
            $display("cartesian_cell_to_simplex_indices_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ccsi_pkg.sv
rtl/ccsi_stream_if.sv
rtl/ccsi_fifo.sv
rtl/ccsi_front.sv
rtl/ccsi_back.sv
rtl/cartesian_cell_to_simplex_indices_top.sv
dv/tb_top.sv
